>>> hw/rtl/continuity_diode_tester_controller_defines.svh
// Assertion helpers shared by the tester RTL.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef CONTINUITY_DIODE_TESTER_CONTROLLER_DEFINES_SVH
`define CONTINUITY_DIODE_TESTER_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define CDTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cdtc: same-cycle check failed");

// Next-cycle implication.
`define CDTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cdtc: next-cycle check failed");

`endif

>>> hw/rtl/cdtc_pkg.sv
`default_nettype none

package cdtc_pkg;

  // Mode codes
  localparam logic [2:0] M_SLEEP = 3'd0;
  localparam logic [2:0] M_CIDLE = 3'd1;
  localparam logic [2:0] M_CBEEP = 3'd2;
  localparam logic [2:0] M_IIDLE = 3'd3;
  localparam logic [2:0] M_IBEEP = 3'd4;
  localparam logic [2:0] M_DIDLE = 3'd5;
  localparam logic [2:0] M_DBEEP = 3'd6;
  localparam logic [2:0] M_DOK   = 3'd7;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_OPEN  = 3'd0;
  localparam logic [2:0] REG_SHORT = 3'd1;
  localparam logic [2:0] REG_LATCH = 3'd2;
  localparam logic [2:0] REG_DMAX  = 3'd3;
  localparam logic [2:0] REG_DMIN  = 3'd4;
  localparam logic [2:0] REG_GOOD  = 3'd5;
  localparam logic [2:0] REG_IDLE  = 3'd6;

  localparam logic [15:0] RST_OPEN  = 16'd192;
  localparam logic [15:0] RST_SHORT = 16'd128;
  localparam logic [6:0]  RST_LATCH = 7'd4;
  localparam logic [15:0] RST_DMAX  = 16'd18560;
  localparam logic [15:0] RST_DMIN  = 16'd1600;
  localparam logic [7:0]  RST_GOOD  = 8'd7;
  localparam logic [15:0] RST_IDLE  = 16'd5000;

  localparam logic signed [7:0] DEB_MAX     = 8'sd127;
  localparam logic signed [7:0] DEB_BLOCKED = -8'sd1;
  localparam logic [7:0]        RUN_MAX     = 8'd255;

  typedef struct packed {
    logic [15:0] open_thr;
    logic [15:0] short_thr;
    logic [6:0]  latch;
    logic [15:0] dmax;
    logic [15:0] dmin;
    logic [7:0]  good;
    logic [15:0] idle_lim;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [15:0]       idle;
    logic [7:0]        run;
    logic signed [7:0] deb;
    logic              beep;
    logic              led;
  } st_t;

  function automatic st_t enter_mode(st_t s, logic [2:0] m);
    st_t r;
    r = s;
    r.mode = m;
    unique case (m)
      M_SLEEP: begin
        r.beep = 1'b0;
        r.led  = 1'b0;
      end
      M_CIDLE, M_IIDLE, M_DIDLE: begin
        r.beep = 1'b0;
        r.led  = 1'b0;
        r.idle = '0;
      end
      M_CBEEP, M_IBEEP, M_DBEEP: begin
        r.beep = 1'b1;
        r.led  = 1'b1;
        r.run  = '0;
      end
      M_DOK: begin
        r.beep = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cdtc_step.sv
`default_nettype none

module cdtc_step import cdtc_pkg::*; (
  input  cfg_t        cfg_i,
  input  st_t         st_i,
  input  logic [15:0] sample_i,
  input  logic        button_i,
  input  logic        wake_i,
  output st_t         st_o
);

  logic signed [7:0] deb_inc;
  logic              fire;
  logic [15:0]       idle_inc;
  logic              idle_done;
  logic [7:0]        run_up;
  logic [6:0]        t;

  function automatic logic blink(logic [6:0] tk, logic [1:0] k);
    return ({1'b0, tk[6:4]} < {2'b00, k}) && tk[3] && tk[2];
  endfunction

  // Debounce: count while the button is held, saturate, hold blocked until release.
  always_comb begin
    if (button_i) begin
      if (!st_i.deb[7] && (st_i.deb != DEB_MAX)) begin
        deb_inc = st_i.deb + 8'sd1;
      end else begin
        deb_inc = st_i.deb;
      end
    end else begin
      deb_inc = 8'sd0;
    end
    fire = deb_inc > $signed({1'b0, cfg_i.latch});
  end

  assign idle_inc  = st_i.idle + 16'd1;
  assign idle_done = idle_inc >= cfg_i.idle_lim;
  assign run_up    = (st_i.run == RUN_MAX) ? RUN_MAX : st_i.run + 8'd1;
  assign t         = st_i.idle[6:0];

  always_comb begin
    st_t n;
    logic [7:0] run_n;
    n = st_i;
    run_n = '0;
    unique case (st_i.mode)
      M_SLEEP: begin
        if (button_i || wake_i) n = enter_mode(n, M_CIDLE);
      end
      M_CIDLE: begin
        n.led = blink(t, 2'd1);
        n.deb = fire ? DEB_BLOCKED : deb_inc;
        if (fire) n = enter_mode(n, M_IIDLE);
        else if (sample_i < cfg_i.short_thr) n = enter_mode(n, M_CBEEP);
        else begin
          n.idle = idle_inc;
          if (idle_done) n = enter_mode(n, M_SLEEP);
        end
      end
      M_IIDLE: begin
        n.led = blink(t, 2'd2);
        n.deb = fire ? DEB_BLOCKED : deb_inc;
        if (fire) n = enter_mode(n, M_DIDLE);
        else if (sample_i > cfg_i.open_thr) n = enter_mode(n, M_IBEEP);
        else begin
          n.idle = idle_inc;
          if (idle_done) n = enter_mode(n, M_SLEEP);
        end
      end
      M_DIDLE: begin
        n.led = blink(t, 2'd3);
        n.deb = fire ? DEB_BLOCKED : deb_inc;
        if (fire) n = enter_mode(n, M_CIDLE);
        else if (sample_i < cfg_i.dmax) n = enter_mode(n, M_DBEEP);
        else begin
          n.idle = idle_inc;
          if (idle_done) n = enter_mode(n, M_SLEEP);
        end
      end
      M_CBEEP: begin
        n.deb = fire ? DEB_BLOCKED : deb_inc;
        if (fire) n = enter_mode(n, M_IIDLE);
        else begin
          run_n = (sample_i > cfg_i.open_thr) ? run_up : 8'd0;
          n.run = run_n;
          if (run_n >= {1'b0, cfg_i.latch}) n = enter_mode(n, M_CIDLE);
        end
      end
      M_IBEEP: begin
        n.deb = fire ? DEB_BLOCKED : deb_inc;
        if (fire) n = enter_mode(n, M_DIDLE);
        else begin
          run_n = (sample_i < cfg_i.short_thr) ? run_up : 8'd0;
          n.run = run_n;
          if (run_n >= {1'b0, cfg_i.latch}) n = enter_mode(n, M_IIDLE);
        end
      end
      M_DBEEP: begin
        n.deb = fire ? DEB_BLOCKED : deb_inc;
        if (fire) n = enter_mode(n, M_CIDLE);
        else if (sample_i > cfg_i.dmax) n = enter_mode(n, M_DIDLE);
        else begin
          run_n = (sample_i > cfg_i.dmin) ? run_up : 8'd0;
          n.run = run_n;
          if (run_n >= cfg_i.good) n = enter_mode(n, M_DOK);
        end
      end
      M_DOK: begin
        // Button only looked at while the diode stays connected.
        if (sample_i > cfg_i.dmax) n = enter_mode(n, M_DIDLE);
        else begin
          n.deb = fire ? DEB_BLOCKED : deb_inc;
          if (fire) n = enter_mode(n, M_CIDLE);
        end
      end
    endcase
    st_o = n;
  end

endmodule

`default_nettype wire

>>> hw/rtl/continuity_diode_tester_controller.sv
// Continuity / diode tester controller.
// Input stream: one word per sample tick with the probe ADC sample and the
// raw button and probe-wake levels. Output stream: one word per input word
// with the mode, the beeper enable and the LED level after that tick.
// An APB port sets thresholds, latch and good counts and the idle timeout;
// write it only while no word is in flight.
// Path: an accepted word is held in the input register and its result is
// then written to the result register, from which the result word is
// offered. Throughput: one word per cycle while the receiver keeps taking
// results; the mode state is updated by one pass of compare/count logic
// between the input register and the result register.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; after that s_axis_tready drops until
// the result is taken.
// Reset puts the tester in sleep with beeper and LED off, all counters
// cleared and all registers at their default values; no word is held.
`default_nettype none

`include "continuity_diode_tester_controller_defines.svh"

module continuity_diode_tester_controller import cdtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [15:0] adc_sample, [16] button_pressed, [17] probe_wake, [23:18] zero
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [2:0] mode, [3] beeper_on, [4] led_on, [7:5] zero
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg_q;
  st_t         st_q, st_d;
  logic        in_vld_q;
  logic [15:0] sample_q;
  logic        button_q;
  logic        wake_q;
  logic        out_vld_q;
  logic [4:0]  out_q;
  logic        adv;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_thr  <= RST_OPEN;
      cfg_q.short_thr <= RST_SHORT;
      cfg_q.latch     <= RST_LATCH;
      cfg_q.dmax      <= RST_DMAX;
      cfg_q.dmin      <= RST_DMIN;
      cfg_q.good      <= RST_GOOD;
      cfg_q.idle_lim  <= RST_IDLE;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_OPEN:  cfg_q.open_thr  <= pwdata[15:0];
        REG_SHORT: cfg_q.short_thr <= pwdata[15:0];
        REG_LATCH: cfg_q.latch     <= pwdata[6:0];
        REG_DMAX:  cfg_q.dmax      <= pwdata[15:0];
        REG_DMIN:  cfg_q.dmin      <= pwdata[15:0];
        REG_GOOD:  cfg_q.good      <= pwdata[7:0];
        REG_IDLE:  cfg_q.idle_lim  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_OPEN:  prdata = {16'd0, cfg_q.open_thr};
      REG_SHORT: prdata = {16'd0, cfg_q.short_thr};
      REG_LATCH: prdata = {25'd0, cfg_q.latch};
      REG_DMAX:  prdata = {16'd0, cfg_q.dmax};
      REG_DMIN:  prdata = {16'd0, cfg_q.dmin};
      REG_GOOD:  prdata = {24'd0, cfg_q.good};
      REG_IDLE:  prdata = {16'd0, cfg_q.idle_lim};
      default:   prdata = '0;
    endcase
  end

  // Advance the held word when the result register is free or being drained.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sample_q <= s_axis_tdata[15:0];
      button_q <= s_axis_tdata[16];
      wake_q   <= s_axis_tdata[17];
    end
  end

  cdtc_step u_step (
    .cfg_i   (cfg_q),
    .st_i    (st_q),
    .sample_i(sample_q),
    .button_i(button_q),
    .wake_i  (wake_q),
    .st_o    (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode <= M_SLEEP;
      st_q.idle <= '0;
      st_q.run  <= '0;
      st_q.deb  <= '0;
      st_q.beep <= 1'b0;
      st_q.led  <= 1'b0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {st_d.led, st_d.beep, st_d.mode};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'd0, out_q};

  `CDTC_ASSERT_IMP(a_sleep_dark, st_q.mode == M_SLEEP, !st_q.beep && !st_q.led)
  `CDTC_ASSERT_IMP(a_beep_mode, st_q.beep,
                   st_q.mode == M_CBEEP || st_q.mode == M_IBEEP || st_q.mode == M_DBEEP)
  `CDTC_ASSERT_IMP(a_deb_range, 1'b1, st_q.deb >= DEB_BLOCKED)
  `CDTC_ASSERT_IMP(a_stall_cause, !s_axis_tready, in_vld_q && m_axis_tvalid && !m_axis_tready)
  `CDTC_ASSERT_NEXT(a_state_hold, !adv, $stable(st_q))

endmodule

`default_nettype wire
